// ----- hdl/cbti_pkg.sv -----
// Shared types and constants for the custom base text to integer converter.
// Used by cbti_alphabet and custom_base_text_to_integer; depends on nothing.
package cbti_pkg;

   localparam int ALPHABET_SIZE = 256;
   localparam int LEN_W         = $clog2(ALPHABET_SIZE + 1);
   localparam int CHAR_W        = 8;
   localparam int CHAR_COUNT    = 1 << CHAR_W;
   localparam int DIGIT_W       = 8;
   localparam int ACC_W         = 32;
   localparam int FUNC_W        = 2;

   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_STRING = 2'd2;

   localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [CHAR_W-1:0] ch;
      logic              first;
   } req_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] value;
      logic                    base_ok;
      logic                    stopped;
   } rsp_type;

   typedef struct packed {
      logic               digit_valid;
      logic [DIGIT_W-1:0] digit_value;
      logic [LEN_W-1:0]   length;
      logic               base_ok;
   } lookup_type;

endpackage

// ----- hdl/cbti_alphabet.sv -----
// Digit alphabet store: valid bits, digit value memory, length and bad flag.
// Updates on each accepted word and registers the lookup for that word's character.
// Depends on cbti_pkg.
module cbti_alphabet (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  cbti_pkg::req_type    req,
   output cbti_pkg::lookup_type lookup
);

   logic [cbti_pkg::CHAR_COUNT-1:0] valid_ff;
   logic [cbti_pkg::CHAR_COUNT-1:0] valid_in;
   logic [cbti_pkg::LEN_W-1:0]      len_ff;
   logic [cbti_pkg::LEN_W-1:0]      len_in;
   logic                            bad_ff;
   logic                            bad_in;
   logic                            write_en;
   logic [cbti_pkg::DIGIT_W-1:0]    value_mem [cbti_pkg::CHAR_COUNT];
   cbti_pkg::lookup_type            lookup_ff;

   always_comb begin
      valid_in = valid_ff;
      len_in   = len_ff;
      bad_in   = bad_ff;
      write_en = 1'b0;
      case (req.func)
         cbti_pkg::FUNC_CLEAR: begin
            valid_in = '0;
            len_in   = '0;
            bad_in   = 1'b0;
         end
         cbti_pkg::FUNC_APPEND: begin
            if (req.ch == cbti_pkg::CH_NUL || req.ch == cbti_pkg::CH_PLUS ||
                req.ch == cbti_pkg::CH_MINUS || valid_ff[req.ch] ||
                len_ff >= cbti_pkg::LEN_W'(cbti_pkg::ALPHABET_SIZE)) begin
               bad_in = 1'b1;
            end else begin
               valid_in[req.ch] = 1'b1;
               len_in           = len_ff + 1'b1;
               write_en         = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         len_ff   <= '0;
         bad_ff   <= 1'b0;
      end else if (accept) begin
         valid_ff <= valid_in;
         len_ff   <= len_in;
         bad_ff   <= bad_in;
      end
   end

   // The digit lookup sees the alphabet as it stood before this word, and the length and
   // base_ok as they stand after it; a string word never changes the alphabet, so both agree.
   always_ff @(posedge clock) begin
      if (accept) begin
         if (write_en) begin
            value_mem[req.ch] <= cbti_pkg::DIGIT_W'(len_ff);
         end
         lookup_ff.digit_value <= value_mem[req.ch];
         lookup_ff.digit_valid <= valid_ff[req.ch];
         lookup_ff.length      <= len_in;
         lookup_ff.base_ok     <= !bad_in && (len_in >= cbti_pkg::LEN_W'(2));
      end
   end

   assign lookup = lookup_ff;

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= cbti_pkg::LEN_W'(cbti_pkg::ALPHABET_SIZE))
      else $error("Alphabet length exceeds its maximum.");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      $past(accept) && !$past(reset) && $past(req.func) == cbti_pkg::FUNC_CLEAR
      |-> len_ff == '0 && valid_ff == '0 && !bad_ff)
      else $error("Clear did not empty the alphabet.");

   a_lookup_state: assert property (@(posedge clock) disable iff (reset)
      $past(accept) && !$past(reset)
      |-> lookup_ff.base_ok == (!bad_ff && len_ff >= cbti_pkg::LEN_W'(2)) &&
          lookup_ff.length == len_ff)
      else $error("Registered lookup disagrees with the alphabet state.");

endmodule

// ----- hdl/custom_base_text_to_integer.sv -----
// Top level of the custom base text to integer converter: handshake, parse
// state and result register. Depends on cbti_pkg and cbti_alphabet.
//
//   Channel  Direction  Handshake              Word
//   req      in         req_valid / req_ready  cbti_pkg::req_type
//   rsp      out        rsp_valid / rsp_ready  cbti_pkg::rsp_type
//
// One word is accepted per cycle while the result is not stalled; each word gives one result,
// registered first in the digit lookup and then in the result register.
// Reset is synchronous and empties the alphabet and the parse state at once.
// A stalled result holds the pipeline; req_ready falls only when both stages are full.
module custom_base_text_to_integer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cbti_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cbti_pkg::rsp_type rsp_word
);

   typedef enum logic [1:0] {
      PH_SPACE,
      PH_SIGN,
      PH_DIGIT,
      PH_STOP
   } phase_type;

   logic                       accept;
   logic                       s1_adv;
   logic                       s1_valid_ff;
   cbti_pkg::req_type          s1_req_ff;
   cbti_pkg::lookup_type       s1_lookup;
   logic                       rsp_valid_ff;
   cbti_pkg::rsp_type          rsp_word_ff;
   cbti_pkg::rsp_type          rsp_word_in;
   phase_type                  phase_ff;
   phase_type                  phase_in;
   logic                       neg_ff;
   logic                       neg_in;
   logic [cbti_pkg::ACC_W-1:0] acc_ff;
   logic [cbti_pkg::ACC_W-1:0] acc_in;
   logic                       restart;
   logic                       is_space;

   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign accept    = req_valid && req_ready;

   cbti_alphabet u_alphabet (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_word),
      .lookup (s1_lookup)
   );

   assign restart  = s1_req_ff.func == cbti_pkg::FUNC_STRING && s1_req_ff.first;
   assign is_space = s1_req_ff.ch == cbti_pkg::CH_SPACE ||
                     (s1_req_ff.ch >= cbti_pkg::CH_TAB && s1_req_ff.ch <= cbti_pkg::CH_CR);

   // The phases fall through in one pass, so a character that ends one phase
   // is handled again by the next.
   always_comb begin
      phase_in = restart ? PH_SPACE : phase_ff;
      neg_in   = restart ? 1'b0 : neg_ff;
      acc_in   = restart ? '0 : acc_ff;
      if (s1_req_ff.func == cbti_pkg::FUNC_STRING) begin
         if (phase_in == PH_SPACE && !is_space) begin
            phase_in = PH_SIGN;
         end
         if (phase_in == PH_SIGN) begin
            if (s1_req_ff.ch == cbti_pkg::CH_MINUS) begin
               neg_in = !neg_in;
            end else if (s1_req_ff.ch != cbti_pkg::CH_PLUS) begin
               phase_in = PH_DIGIT;
            end
         end
         if (phase_in == PH_DIGIT) begin
            if (s1_lookup.digit_valid) begin
               acc_in = acc_in * cbti_pkg::ACC_W'(s1_lookup.length) +
                        cbti_pkg::ACC_W'(s1_lookup.digit_value);
            end else begin
               phase_in = PH_STOP;
            end
         end
      end
      rsp_word_in.base_ok = s1_lookup.base_ok;
      rsp_word_in.stopped = phase_in == PH_STOP;
      if (!s1_lookup.base_ok) begin
         rsp_word_in.value = '0;
      end else if (neg_in) begin
         rsp_word_in.value = -$signed(acc_in);
      end else begin
         rsp_word_in.value = $signed(acc_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_SPACE;
         neg_ff       <= 1'b0;
         acc_ff       <= '0;
      end else begin
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (s1_adv) begin
            rsp_valid_ff <= 1'b1;
            phase_ff     <= phase_in;
            neg_ff       <= neg_in;
            acc_ff       <= acc_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff <= req_word;
      end
      if (s1_adv) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.base_ok |-> rsp_word.value == '0)
      else $error("Nonzero value reported with an invalid base.");

   a_stop_sticky: assert property (@(posedge clock) disable iff (reset)
      $past(phase_ff) == PH_STOP && !$past(reset) && !($past(s1_adv) && $past(restart))
      |-> phase_ff == PH_STOP)
      else $error("Parse left the stopped phase without a new string.");

   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_ready)
      else $error("Input stalled while the lookup stage was empty.");

endmodule

// ----- tb/custom_base_text_to_integer_tb.sv -----
// Self-checking testbench for custom_base_text_to_integer: a directed script, then random
// alphabets and strings, checked word by word against an in-bench converter model or a pinned result.
// Depends on cbti_pkg and the RTL of custom_base_text_to_integer.
`timescale 1ns / 100ps

module custom_base_text_to_integer_tb;

   localparam logic [cbti_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int DIRECTED_ROWS = 28;
   localparam int RANDOM_WORDS  = 370;
   localparam int HOLD_CYCLES   = 300;
   localparam int IDLE_LIMIT    = 2000;
   localparam int FULL_BASE     = cbti_pkg::CHAR_COUNT - 3;

   typedef enum bit [1:0] {SCAN_SPACE, SCAN_SIGN, SCAN_DIGIT, SCAN_DONE} scan_state_type;

   typedef struct packed {
      cbti_pkg::req_type word;
      logic              pinned;
      cbti_pkg::rsp_type rsp;
   } script_row_type;

   localparam script_row_type SCRIPT [DIRECTED_ROWS] = '{
      '{'{cbti_pkg::FUNC_STRING, "7", 1'b1},       1'b1, '{32'sd0, 1'b0, 1'b1}},
      '{'{FUNC_UNUSED, 8'hFF, 1'b1},               1'b1, '{32'sd0, 1'b0, 1'b1}},
      '{'{cbti_pkg::FUNC_CLEAR, 8'hFF, 1'b1},      1'b1, '{32'sd0, 1'b0, 1'b1}},
      '{'{cbti_pkg::FUNC_APPEND, "0", 1'b0},       1'b1, '{32'sd0, 1'b0, 1'b1}},
      '{'{cbti_pkg::FUNC_APPEND, "1", 1'b1},       1'b1, '{32'sd0, 1'b1, 1'b1}},
      '{'{cbti_pkg::FUNC_APPEND, cbti_pkg::CH_PLUS, 1'b0},  1'b1, '{32'sd0, 1'b0, 1'b1}},
      '{'{cbti_pkg::FUNC_CLEAR, 8'h00, 1'b0},      1'b1, '{32'sd0, 1'b0, 1'b1}},
      '{'{cbti_pkg::FUNC_APPEND, cbti_pkg::CH_MINUS, 1'b0}, 1'b1, '{32'sd0, 1'b0, 1'b1}},
      '{'{cbti_pkg::FUNC_CLEAR, 8'h55, 1'b0},      1'b1, '{32'sd0, 1'b0, 1'b1}},
      '{'{cbti_pkg::FUNC_APPEND, cbti_pkg::CH_NUL, 1'b0},   1'b1, '{32'sd0, 1'b0, 1'b1}},
      '{'{cbti_pkg::FUNC_CLEAR, 8'hAA, 1'b1},      1'b1, '{32'sd0, 1'b0, 1'b1}},
      '{'{cbti_pkg::FUNC_APPEND, 8'hFF, 1'b0},     1'b1, '{32'sd0, 1'b0, 1'b1}},
      '{'{cbti_pkg::FUNC_APPEND, 8'hFE, 1'b0},     1'b1, '{32'sd0, 1'b1, 1'b1}},
      '{'{cbti_pkg::FUNC_APPEND, 8'hFF, 1'b0},     1'b1, '{32'sd0, 1'b0, 1'b1}},
      '{'{cbti_pkg::FUNC_CLEAR, 8'h00, 1'b0},      1'b1, '{32'sd0, 1'b0, 1'b1}},
      '{'{cbti_pkg::FUNC_APPEND, "0", 1'b0},       1'b1, '{32'sd0, 1'b0, 1'b1}},
      '{'{cbti_pkg::FUNC_APPEND, "1", 1'b0},       1'b1, '{32'sd0, 1'b1, 1'b1}},
      '{'{cbti_pkg::FUNC_STRING, cbti_pkg::CH_SPACE, 1'b1}, 1'b1, '{32'sd0, 1'b1, 1'b0}},
      '{'{cbti_pkg::FUNC_STRING, cbti_pkg::CH_TAB, 1'b0},   1'b1, '{32'sd0, 1'b1, 1'b0}},
      '{'{cbti_pkg::FUNC_STRING, cbti_pkg::CH_CR, 1'b0},    1'b1, '{32'sd0, 1'b1, 1'b0}},
      '{'{cbti_pkg::FUNC_STRING, cbti_pkg::CH_MINUS, 1'b0}, 1'b1, '{32'sd0, 1'b1, 1'b0}},
      '{'{cbti_pkg::FUNC_STRING, cbti_pkg::CH_PLUS, 1'b0},  1'b1, '{32'sd0, 1'b1, 1'b0}},
      '{'{cbti_pkg::FUNC_STRING, "1", 1'b0},       1'b1, '{-32'sd1, 1'b1, 1'b0}},
      '{'{cbti_pkg::FUNC_STRING, "0", 1'b0},       1'b0, '0},
      '{'{cbti_pkg::FUNC_STRING, cbti_pkg::CH_NUL, 1'b0},   1'b0, '0},
      '{'{cbti_pkg::FUNC_STRING, "1", 1'b1},       1'b0, '0},
      '{'{cbti_pkg::FUNC_CLEAR, 8'h00, 1'b0},      1'b1, '{32'sd0, 1'b0, 1'b0}},
      '{'{cbti_pkg::FUNC_STRING, "1", 1'b0},       1'b1, '{32'sd0, 1'b0, 1'b1}}
   };

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   cbti_pkg::req_type req_word;
   logic              rsp_valid;
   logic              rsp_ready;
   cbti_pkg::rsp_type rsp_word;

   logic              pin_on;
   cbti_pkg::rsp_type pin_rsp;

   // Converter model state.
   bit [cbti_pkg::DIGIT_W-1:0] digit_of [cbti_pkg::CHAR_COUNT];
   bit                         is_digit [cbti_pkg::CHAR_COUNT];
   bit [cbti_pkg::LEN_W-1:0]   base_len;
   bit                         base_bad;
   scan_state_type             scan_state;
   bit                         minus;
   bit [cbti_pkg::ACC_W-1:0]   total;

   cbti_pkg::rsp_type expected_q [$];
   int      fail_count;
   int      words_sent;
   int      word_target;
   int      strings_sent;
   int      alphabets_loaded;
   int      largest_base;
   int      ok_results;
   int      stopped_results;
   int      negative_results;
   bit      steady;
   bit      hold_req;

   custom_base_text_to_integer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic cbti_pkg::rsp_type convert_word(cbti_pkg::req_type w);
      cbti_pkg::rsp_type           r;
      bit                          ok;
      bit                          taken;
      logic [cbti_pkg::CHAR_W-1:0] c;
      c = w.ch;
      case (w.func)
         cbti_pkg::FUNC_CLEAR: begin
            for (int i = 0; i < cbti_pkg::CHAR_COUNT; i++) is_digit[i] = 1'b0;
            base_len = '0;
            base_bad = 1'b0;
         end
         cbti_pkg::FUNC_APPEND: begin
            if (c == cbti_pkg::CH_NUL || c == cbti_pkg::CH_PLUS || c == cbti_pkg::CH_MINUS
                || is_digit[c] || base_len >= cbti_pkg::ALPHABET_SIZE) begin
               base_bad = 1'b1;
            end else begin
               is_digit[c] = 1'b1;
               digit_of[c] = base_len[cbti_pkg::DIGIT_W-1:0];
               base_len = base_len + 1'b1;
            end
         end
         cbti_pkg::FUNC_STRING: begin
            if (w.first) begin
               scan_state = SCAN_SPACE;
               minus = 1'b0;
               total = '0;
            end
            taken = 1'b0;
            if (scan_state == SCAN_SPACE) begin
               if (c == cbti_pkg::CH_SPACE || (c >= cbti_pkg::CH_TAB && c <= cbti_pkg::CH_CR))
                  taken = 1'b1;
               else scan_state = SCAN_SIGN;
            end
            if (!taken && scan_state == SCAN_SIGN) begin
               if (c == cbti_pkg::CH_MINUS) begin
                  minus = !minus;
                  taken = 1'b1;
               end else if (c == cbti_pkg::CH_PLUS) begin
                  taken = 1'b1;
               end else begin
                  scan_state = SCAN_DIGIT;
               end
            end
            if (!taken && scan_state == SCAN_DIGIT) begin
               if (is_digit[c])
                  total = total * cbti_pkg::ACC_W'(base_len) + cbti_pkg::ACC_W'(digit_of[c]);
               else scan_state = SCAN_DONE;
            end
         end
         default: ;
      endcase
      ok = !base_bad && base_len >= 2;
      r.value   = ok ? (minus ? (cbti_pkg::ACC_W'(0) - total) : total) : '0;
      r.base_ok = ok;
      r.stopped = (scan_state == SCAN_DONE);
      return r;
   endfunction

   task automatic send_word(input cbti_pkg::req_type w, input bit pinned,
                            input cbti_pkg::rsp_type pinned_rsp);
      int gap;
      if (!steady && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 16);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_word  <= w;
      pin_on    <= pinned;
      pin_rsp   <= pinned_rsp;
      do @(posedge clock); while (!req_ready);
      if (w.func != FUNC_UNUSED) words_sent++;
   endtask

   task automatic send_char(input logic [cbti_pkg::FUNC_W-1:0] func,
                            input logic [cbti_pkg::CHAR_W-1:0] ch, input logic first);
      cbti_pkg::req_type w;
      w.func  = func;
      w.ch    = ch;
      w.first = first;
      send_word(w, 1'b0, '0);
   endtask

   always @(posedge clock) begin
      cbti_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("Unexpected result word: value=%0d base_ok=%0b stopped=%0b",
                           $signed(rsp_word.value), rsp_word.base_ok, rsp_word.stopped);
            end else begin
               want = expected_q.pop_front();
               if (rsp_word.value !== want.value || rsp_word.base_ok !== want.base_ok
                   || rsp_word.stopped !== want.stopped) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("Mismatch: expected value=%0d base_ok=%0b stopped=%0b",
                              $signed(want.value), want.base_ok, want.stopped);
                     $display("          got value=%0d base_ok=%0b stopped=%0b",
                              $signed(rsp_word.value), rsp_word.base_ok, rsp_word.stopped);
                  end
               end
            end
            if (rsp_word.base_ok === 1'b1) ok_results++;
            if (rsp_word.stopped === 1'b1) stopped_results++;
            if ($signed(rsp_word.value) < 0) negative_results++;
         end
         if (req_valid && req_ready) begin
            want = convert_word(req_word);
            if (pin_on) want = pin_rsp;
            expected_q.push_back(want);
         end
      end
   end

   initial begin : receiver
      int hold_left;
      int burst_left;
      bit level;
      hold_left  = 0;
      burst_left = 0;
      level      = 1'b1;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (steady) begin
            rsp_ready <= 1'b1;
         end else begin
            if (burst_left == 0) begin
               level = ($urandom_range(0, 2) != 0);
               if (level && $urandom_range(0, 4) == 0) burst_left = $urandom_range(17, 60);
               else burst_left = $urandom_range(1, 16);
            end
            burst_left--;
            rsp_ready <= level;
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("Timeout: no word moved for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, expected_q.size());
      $display("*** FAILED ***");
      $finish;
   end

   initial begin : stimulus
      int                          i;
      int                          k;
      int                          n;
      int                          bad_at;
      int                          session;
      int                          nstr;
      int                          len;
      bit                          used [cbti_pkg::CHAR_COUNT];
      logic [cbti_pkg::CHAR_W-1:0] alpha [$];
      logic [cbti_pkg::CHAR_W-1:0] text_q [$];
      logic [cbti_pkg::CHAR_W-1:0] c;
      bit                          lead_first;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_word  = '0;
      rsp_ready = 1'b0;
      pin_on    = 1'b0;
      pin_rsp   = '0;
      steady    = 1'b0;
      hold_req  = 1'b0;
      fail_count = 0;
      words_sent = 0;
      strings_sent = 0;
      alphabets_loaded = 0;
      largest_base = 0;
      ok_results = 0;
      stopped_results = 0;
      negative_results = 0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIRECTED_ROWS; i++)
         send_word(SCRIPT[i].word, SCRIPT[i].pinned, SCRIPT[i].rsp);

      word_target = words_sent + RANDOM_WORDS;
      session = 0;
      while (words_sent < word_target) begin
         session++;
         steady = (words_sent >= word_target - 80);
         if (session == 1) hold_req = 1'b1;

         if (session <= 3 || $urandom_range(0, 7) != 0) begin
            if (session == 1) begin
               n = FULL_BASE;
            end else if ($urandom_range(0, 11) == 0) begin
               n = $urandom_range(0, 1);
            end else if ($urandom_range(0, 5) == 0) begin
               n = $urandom_range(17, 64);
            end else begin
               n = $urandom_range(2, 16);
            end
            send_char(cbti_pkg::FUNC_CLEAR, cbti_pkg::CHAR_W'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
            alpha.delete();
            for (i = 0; i < cbti_pkg::CHAR_COUNT; i++) used[i] = 1'b0;
            bad_at = (n > 0 && $urandom_range(0, 5) == 0) ? $urandom_range(0, n - 1) : -1;
            for (k = 0; k < n; k++) begin
               if (k == bad_at) begin
                  if (alpha.size() > 0 && $urandom_range(0, 1) == 0)
                     c = alpha[$urandom_range(0, alpha.size() - 1)];
                  else
                     case ($urandom_range(0, 2))
                        0: c = cbti_pkg::CH_NUL;
                        1: c = cbti_pkg::CH_PLUS;
                        default: c = cbti_pkg::CH_MINUS;
                     endcase
                  send_char(cbti_pkg::FUNC_APPEND, c, 1'($urandom_range(0, 1)));
               end
               do c = cbti_pkg::CHAR_W'($urandom_range(0, 255));
               while (used[c] || c == cbti_pkg::CH_NUL || c == cbti_pkg::CH_PLUS
                      || c == cbti_pkg::CH_MINUS);
               used[c] = 1'b1;
               alpha.push_back(c);
               send_char(cbti_pkg::FUNC_APPEND, c, 1'($urandom_range(0, 1)));
            end
            if (session == 1) send_char(cbti_pkg::FUNC_APPEND, alpha[0], 1'b0);
            alphabets_loaded++;
            if (n > largest_base) largest_base = n;
            if (session == 1 || (!steady && $urandom_range(0, 3) == 0)) begin
               @(negedge clock);
               req_valid <= 1'b0;
               while (expected_q.size() != 0) @(negedge clock);
            end
         end

         nstr = $urandom_range(1, 4);
         for (i = 0; i < nstr; i++) begin
            text_q.delete();
            lead_first = ($urandom_range(0, 9) != 0);
            len = $urandom_range(0, 3);
            for (k = 0; k < len; k++) begin
               n = $urandom_range(8, 13);
               text_q.push_back(n == 8 ? cbti_pkg::CH_SPACE : cbti_pkg::CHAR_W'(n));
            end
            len = $urandom_range(0, 3);
            for (k = 0; k < len; k++)
               text_q.push_back($urandom_range(0, 1) ? cbti_pkg::CH_PLUS : cbti_pkg::CH_MINUS);
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
            if (alpha.size() > 0)
               for (k = 0; k < len; k++)
                  text_q.push_back(alpha[$urandom_range(0, alpha.size() - 1)]);
            if ($urandom_range(0, 2) != 0) begin
               do c = cbti_pkg::CHAR_W'($urandom_range(0, 255));
               while (used[c]);
               text_q.push_back(c);
            end
            len = $urandom_range(0, 2);
            for (k = 0; k < len; k++)
               text_q.push_back(cbti_pkg::CHAR_W'($urandom_range(0, 255)));
            for (k = 0; k < text_q.size(); k++)
               send_char(cbti_pkg::FUNC_STRING, text_q[k], k == 0 && lead_first);
            strings_sent++;
            if ($urandom_range(0, 3) == 0)
               send_char(cbti_pkg::FUNC_W'($urandom_range(0, 3)),
                         cbti_pkg::CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);

      $display("Sent %0d words: %0d alphabets (largest base %0d), %0d strings parsed.",
               words_sent, alphabets_loaded, largest_base, strings_sent);
      $display("Results: %0d with a valid base, %0d stopped, %0d negative, %0d failures.",
               ok_results, stopped_results, negative_results, fail_count);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
